/* rtl/core/cpp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_pkg
// Shared constants and types for the closest pair of points block.
// ----------------------------------------------------------------------------
package cpp_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 16;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int SQ_W       = 2 * COORD_BITS + 1;
  localparam int POINT_W    = 2 * COORD_BITS;

  // job queue between front and back, power of two
  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0]        mag_t;
  typedef logic [2*COORD_BITS-1:0]      sq_t;
  typedef logic [SQ_W-1:0]              dist_t;
  typedef logic [ADDR_W-1:0]            addr_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    cnt_t count;
    logic overflow;
  } job_t;

  typedef struct packed {
    logic   en;
    addr_t  addr;
    point_t data;
  } mem_wr_t;

endpackage

/* rtl/core/closest_pair_of_points.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_pair_of_points
// Exact closest pair of a set of 2D points by squared Euclidean distance.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one point per transaction, one per cycle while the
//   set is loading. in_last_point closes the set and starts the search.
//   Points beyond MAX_POINTS are dropped and reported in out_overflowed.
//   Output channel (out_*): one result per set, both points in load order
//   and the squared distance; out_result_valid is 0 with fewer than two
//   points, and then the other fields are 0.
//   The pair sweep reads one point per cycle from the single read
//   port of the point memory.
//   Throughput: one point per cycle during loading; after the closing point
//   in_ready stays low until the result transaction completes.
//   Stall: the result is held in registers while out_ready is low.
//   Reset (rst_n low, synchronous) empties the set and the job queue; the
//   point memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module closest_pair_of_points (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cpp_pkg::coord_t in_point_x,
  input  cpp_pkg::coord_t in_point_y,
  input  logic            in_last_point,
  output logic            out_valid,
  input  logic            out_ready,
  output cpp_pkg::coord_t out_first_x,
  output cpp_pkg::coord_t out_first_y,
  output cpp_pkg::coord_t out_second_x,
  output cpp_pkg::coord_t out_second_y,
  output cpp_pkg::dist_t  out_squared_distance,
  output logic            out_result_valid,
  output logic            out_overflowed
);
  import cpp_pkg::*;

  mem_wr_t mem_wr;
  logic    job_push, job_full, job_pop, job_valid;
  job_t    job_in, job_out;
  logic    rd_en;
  addr_t   rd_addr;
  point_t  rd_data;
  logic    done;

  cpp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_last_point (in_last_point),
    .mem_wr        (mem_wr),
    .job_push      (job_push),
    .job_data      (job_in),
    .job_full      (job_full),
    .done          (done)
  );

  cpp_ram #(
    .WIDTH (POINT_W),
    .DEPTH (MAX_POINTS)
  ) u_point_ram (
    .clk     (clk),
    .wr_en   (mem_wr.en),
    .wr_addr (mem_wr.addr),
    .wr_data (mem_wr.data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cpp_job_queue u_job_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_out),
    .not_empty (job_valid)
  );

  cpp_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .job_valid            (job_valid),
    .job_data             (job_out),
    .job_pop              (job_pop),
    .rd_en                (rd_en),
    .rd_addr              (rd_addr),
    .rd_data              (rd_data),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_first_x          (out_first_x),
    .out_first_y          (out_first_y),
    .out_second_x         (out_second_x),
    .out_second_y         (out_second_y),
    .out_squared_distance (out_squared_distance),
    .out_result_valid     (out_result_valid),
    .out_overflowed       (out_overflowed),
    .done                 (done)
  );

endmodule

/* rtl/core/cpp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cpp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/cpp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_front
// Input side: stores points in load order, tracks count and drops, and
// queues a search job when the final point of a set arrives.
// ----------------------------------------------------------------------------
module cpp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cpp_pkg::coord_t in_point_x,
  input  cpp_pkg::coord_t in_point_y,
  input  logic            in_last_point,
  output cpp_pkg::mem_wr_t mem_wr,
  output logic            job_push,
  output cpp_pkg::job_t   job_data,
  input  logic            job_full,
  input  logic            done
);
  import cpp_pkg::*;

  cnt_t count_r, count_nxt;
  logic ovf_r, ovf_nxt;
  logic busy_r, busy_nxt;
  logic accept;
  logic room;

  // set closed: hold off new points until its result has been taken
  assign in_ready = !busy_r && !job_full;
  assign accept   = in_valid && in_ready;
  assign room     = count_r < cnt_t'(MAX_POINTS);

  assign mem_wr.en   = accept && room;
  assign mem_wr.addr = count_r[ADDR_W-1:0];
  assign mem_wr.data = '{x: in_point_x, y: in_point_y};

  assign job_push          = accept && in_last_point;
  assign job_data.count    = room ? count_r + cnt_t'(1) : count_r;
  assign job_data.overflow = ovf_r || !room;

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    busy_nxt  = busy_r;
    if (done) begin
      busy_nxt = 1'b0;
    end
    if (accept) begin
      if (in_last_point) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
        busy_nxt  = 1'b1;
      end else begin
        count_nxt = job_data.count;
        ovf_nxt   = job_data.overflow;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

/* rtl/core/cpp_job_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_job_queue
// Small register FIFO of search jobs between the front and back ends.
// ----------------------------------------------------------------------------
module cpp_job_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cpp_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output cpp_pkg::job_t pop_data,
  output logic          not_empty
);
  import cpp_pkg::*;

  job_t                  slot_r [JOBQ_DEPTH];
  logic [JOBQ_PTR_W-1:0] wr_ptr_r;
  logic [JOBQ_PTR_W-1:0] rd_ptr_r;
  logic [JOBQ_CNT_W-1:0] cnt_r;

  assign full      = cnt_r == JOBQ_CNT_W'(JOBQ_DEPTH);
  assign not_empty = cnt_r != '0;
  assign pop_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wr_ptr_r + JOBQ_PTR_W'(1);
      end
      if (pop && not_empty) begin
        rd_ptr_r <= rd_ptr_r + JOBQ_PTR_W'(1);
      end
      case ({push && !full, pop && not_empty})
        2'b10:   cnt_r <= cnt_r + JOBQ_CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - JOBQ_CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* rtl/core/cpp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_back
// Search side: sweeps all pairs i < j from the point memory through a
// three-stage distance pipeline and keeps the first strict minimum.
// ----------------------------------------------------------------------------
module cpp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  input  cpp_pkg::job_t    job_data,
  output logic             job_pop,
  output logic             rd_en,
  output cpp_pkg::addr_t   rd_addr,
  input  cpp_pkg::point_t  rd_data,
  output logic             out_valid,
  input  logic             out_ready,
  output cpp_pkg::coord_t  out_first_x,
  output cpp_pkg::coord_t  out_first_y,
  output cpp_pkg::coord_t  out_second_x,
  output cpp_pkg::coord_t  out_second_y,
  output cpp_pkg::dist_t   out_squared_distance,
  output logic             out_result_valid,
  output logic             out_overflowed,
  output logic             done
);
  import cpp_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_FETCH_I = 6'b000010,
    ST_LATCH_I = 6'b000100,
    ST_SWEEP   = 6'b001000,
    ST_DRAIN   = 6'b010000,
    ST_RESULT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  cnt_t   n_r;
  logic   ovf_r;
  addr_t  i_r;
  addr_t  j_r;
  point_t pi_r;
  logic   last_j;
  logic   no_next_i;

  // pipeline: v0 = read data is a j point, s1 = |dx|,|dy|, s2 = squares
  logic   v0_r, v1_r, v2_r;
  point_t s1_p_r, s1_q_r, s2_p_r, s2_q_r;
  mag_t   ax_r, ay_r;
  sq_t    sqx_r, sqy_r;
  dist_t  sum;
  logic   better;

  logic   found_r;
  dist_t  best_r;
  point_t best_p_r, best_q_r;

  function automatic mag_t abs_diff(input coord_t a, input coord_t b);
    logic signed [COORD_BITS:0] d;
    logic signed [COORD_BITS:0] m;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    m = d[COORD_BITS] ? -d : d;
    return m[COORD_BITS-1:0];
  endfunction

  assign last_j    = cnt_t'(j_r) == n_r - cnt_t'(1);
  assign no_next_i = cnt_t'(i_r) + cnt_t'(2) >= n_r;

  assign job_pop = (state_r == ST_IDLE) && job_valid;
  assign rd_en   = (state_r == ST_FETCH_I) || (state_r == ST_SWEEP);
  assign rd_addr = (state_r == ST_SWEEP) ? j_r : i_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          state_nxt = (job_data.count < cnt_t'(2)) ? ST_RESULT : ST_FETCH_I;
        end
      end
      ST_FETCH_I: state_nxt = ST_LATCH_I;
      ST_LATCH_I: state_nxt = ST_SWEEP;
      ST_SWEEP: begin
        if (last_j) begin
          state_nxt = no_next_i ? ST_DRAIN : ST_FETCH_I;
        end
      end
      ST_DRAIN: begin
        if (!v0_r && !v1_r && !v2_r) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v0_r    <= state_r == ST_SWEEP;
      v1_r    <= v0_r;
      v2_r    <= v1_r;
      if (job_pop) begin
        found_r <= 1'b0;
      end else if (v2_r) begin
        found_r <= 1'b1;
      end
    end
  end

  // sequencer counters and job fields
  always_ff @(posedge clk) begin
    if (job_pop) begin
      n_r   <= job_data.count;
      ovf_r <= job_data.overflow;
      i_r   <= '0;
    end
    if (state_r == ST_LATCH_I) begin
      pi_r <= rd_data;
      j_r  <= i_r + addr_t'(1);
    end
    if (state_r == ST_SWEEP) begin
      if (last_j) begin
        if (!no_next_i) begin
          i_r <= i_r + addr_t'(1);
        end
      end else begin
        j_r <= j_r + addr_t'(1);
      end
    end
  end

  assign sum    = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign better = !found_r || (sum < best_r);

  always_ff @(posedge clk) begin
    s1_p_r <= pi_r;
    s1_q_r <= rd_data;
    ax_r   <= abs_diff(pi_r.x, rd_data.x);
    ay_r   <= abs_diff(pi_r.y, rd_data.y);
    s2_p_r <= s1_p_r;
    s2_q_r <= s1_q_r;
    sqx_r  <= ax_r * ax_r;
    sqy_r  <= ay_r * ay_r;
    // strict compare keeps the earliest pair on ties
    if (v2_r && better) begin
      best_r   <= sum;
      best_p_r <= s2_p_r;
      best_q_r <= s2_q_r;
    end
  end

  assign out_valid            = state_r == ST_RESULT;
  assign done                 = out_valid && out_ready;
  assign out_result_valid     = found_r;
  assign out_overflowed       = ovf_r;
  assign out_first_x          = found_r ? best_p_r.x : '0;
  assign out_first_y          = found_r ? best_p_r.y : '0;
  assign out_second_x         = found_r ? best_q_r.x : '0;
  assign out_second_y         = found_r ? best_q_r.y : '0;
  assign out_squared_distance = found_r ? best_r : '0;

endmodule

/* rtl/core/cpp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_checker
// Port-level assertions for closest_pair_of_points, bound to the top level.
// ----------------------------------------------------------------------------
module cpp_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            in_last_point,
  input logic            out_valid,
  input logic            out_ready,
  input cpp_pkg::coord_t out_first_x,
  input cpp_pkg::coord_t out_first_y,
  input cpp_pkg::coord_t out_second_x,
  input cpp_pkg::coord_t out_second_y,
  input cpp_pkg::dist_t  out_squared_distance,
  input logic            out_result_valid,
  input logic            out_overflowed
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_squared_distance)
      && $stable(out_first_x) && $stable(out_first_y)
      && $stable(out_second_x) && $stable(out_second_y)
      && $stable(out_result_valid) && $stable(out_overflowed))
    else $error("result changed while stalled");

  // closing a set blocks the input until its result is taken
  a_close_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_point |=> !in_ready)
    else $error("input accepted after set was closed");

  a_no_load_during_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_valid |-> out_squared_distance == '0
      && out_first_x == '0 && out_second_x == '0)
    else $error("invalid result carries nonzero fields");

endmodule

bind closest_pair_of_points cpp_checker u_cpp_checker (.*);

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for closest_pair_of_points. Point sets are sent over
// the valid/ready input channel and a local pair search predicts each result.
// Every result transaction is compared field by field with the oldest
// prediction. Covered: directed edge sets, a store overflow, random sets
// under several idle and stall mixes, and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import cpp_pkg::*;

  localparam int          HALF_PERIOD = 6;
  localparam int          TAIL_CYCLES = 64;
  localparam int          HOLD_CYCLES = 400;
  localparam int          ITEMS_PER_PHASE = 200;
  localparam longint unsigned DIST_MAX = (64'd1 << SQ_W) - 1;
  // worst sweep over a full store, plus margin for receiver stalls
  localparam int          SEARCH_MAX = MAX_POINTS * (MAX_POINTS - 1) / 2
                                       + 2 * MAX_POINTS + 5;
  localparam int          QUIET_LIMIT = 4 * (SEARCH_MAX + 2 * HOLD_CYCLES);

  localparam coord_t C_MIN = 16'sh8000;
  localparam coord_t C_MAX = 16'sh7fff;

  typedef enum int {STYLE_SPREAD, STYLE_CLUSTER, STYLE_REPEAT, STYLE_CORNER} point_style_t;

  typedef struct packed {
    coord_t first_x;
    coord_t first_y;
    coord_t second_x;
    coord_t second_y;
    dist_t  sq_dist;
    logic   pair_found;
    logic   dropped;
  } pair_result_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t in_point_x = '0;
  coord_t in_point_y = '0;
  logic   in_last_point = 1'b0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  coord_t out_first_x;
  coord_t out_first_y;
  coord_t out_second_x;
  coord_t out_second_y;
  dist_t  out_squared_distance;
  logic   out_result_valid;
  logic   out_overflowed;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_request   = 0;
  int unsigned hold_left      = 0;
  int unsigned mismatch_count = 0;
  int unsigned result_index   = 0;

  // predictor state
  coord_t       set_x [MAX_POINTS];
  coord_t       set_y [MAX_POINTS];
  int unsigned  set_count   = 0;
  bit           set_dropped = 1'b0;
  pair_result_t pending_results[$];

  closest_pair_of_points i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_point_x           (in_point_x),
    .in_point_y           (in_point_y),
    .in_last_point        (in_last_point),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_first_x          (out_first_x),
    .out_first_y          (out_first_y),
    .out_second_x         (out_second_x),
    .out_second_y         (out_second_y),
    .out_squared_distance (out_squared_distance),
    .out_result_valid     (out_result_valid),
    .out_overflowed       (out_overflowed)
  );

  always #HALF_PERIOD clk = ~clk;

  // Store one point; on the closing point sweep all pairs i < j.
  function automatic void predict_point(coord_t x, coord_t y, logic last);
    pair_result_t r;
    longint       dx;
    longint       dy;
    longint unsigned d;
    longint unsigned best;
    bit           found;
    if (set_count < MAX_POINTS) begin
      set_x[set_count] = x;
      set_y[set_count] = y;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!last) return;
    r     = '0;
    best  = 0;
    found = 1'b0;
    for (int unsigned i = 0; i < set_count; i++) begin
      for (int unsigned j = i + 1; j < set_count; j++) begin
        dx = longint'(set_x[i]) - longint'(set_x[j]);
        dy = longint'(set_y[i]) - longint'(set_y[j]);
        d  = dx * dx + dy * dy;
        // strict compare: ties keep the earlier pair
        if (!found || d < best) begin
          found      = 1'b1;
          best       = d;
          r.first_x  = set_x[i];
          r.first_y  = set_y[i];
          r.second_x = set_x[j];
          r.second_y = set_y[j];
        end
      end
    end
    if (found) begin
      r.sq_dist    = (best > DIST_MAX) ? dist_t'(DIST_MAX) : dist_t'(best);
      r.pair_found = 1'b1;
    end
    r.dropped = set_dropped;
    pending_results = {pending_results, r};
    set_count   = 0;
    set_dropped = 1'b0;
  endfunction

  task automatic log_mismatch(input string msg);
    $display("ERROR t=%0t result %0d: %s", $time, result_index, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic signed [63:0] got,
                               input logic signed [63:0] want);
    if (got !== want)
      log_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // One input transaction, with random idle cycles ahead of it.
  task automatic send_point(input coord_t x, input coord_t y, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_point_x    <= x;
    in_point_y    <= y;
    in_last_point <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_point(x, y, last);
  endtask

  task automatic send_random_set(input int unsigned size);
    point_style_t style;
    int           bx;
    int           by;
    int unsigned  pick;
    coord_t       x;
    coord_t       y;
    coord_t       prev_x[$];
    coord_t       prev_y[$];
    style = point_style_t'($urandom_range(0, 3));
    bx    = int'($urandom_range(0, 65520)) - 32760;
    by    = int'($urandom_range(0, 65520)) - 32760;
    for (int unsigned k = 0; k < size; k++) begin
      case (style)
        STYLE_CLUSTER: begin
          x = coord_t'(bx + int'($urandom_range(0, 6)) - 3);
          y = coord_t'(by + int'($urandom_range(0, 6)) - 3);
        end
        STYLE_REPEAT: begin
          if (prev_x.size() != 0 && $urandom_range(0, 2) == 0) begin
            pick = $urandom_range(0, prev_x.size() - 1);
            x    = prev_x[pick];
            y    = prev_y[pick];
          end else begin
            x = coord_t'($urandom);
            y = coord_t'($urandom);
          end
        end
        STYLE_CORNER: begin
          x = $urandom_range(0, 1) ? coord_t'(32767 - int'($urandom_range(0, 3)))
                                   : coord_t'(-32768 + int'($urandom_range(0, 3)));
          y = $urandom_range(0, 1) ? coord_t'(32767 - int'($urandom_range(0, 3)))
                                   : coord_t'(-32768 + int'($urandom_range(0, 3)));
        end
        default: begin
          x = coord_t'($urandom);
          y = coord_t'($urandom);
        end
      endcase
      prev_x = {prev_x, x};
      prev_y = {prev_y, y};
      send_point(x, y, k == size - 1);
    end
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // single point: no pair
    send_point(C_MIN, C_MAX, 1'b1);
    // widest distances, both diagonals
    send_point(C_MIN, C_MIN, 1'b0);
    send_point(C_MAX, C_MAX, 1'b1);
    send_point(C_MAX, C_MIN, 1'b0);
    send_point(C_MIN, C_MAX, 1'b1);
    // equal distances: earliest pair wins
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd1, 16'sd0, 1'b0);
    send_point(16'sd2, 16'sd0, 1'b1);
    // repeated points, three pairs at zero distance
    send_point(16'sd5, -16'sd7, 1'b0);
    send_point(16'sd100, 16'sd100, 1'b0);
    send_point(16'sd5, -16'sd7, 1'b0);
    send_point(16'sd5, -16'sd7, 1'b1);
    // best pair is the last one loaded
    send_point(-16'sd1000, 16'sd300, 1'b0);
    send_point(16'sd2000, -16'sd2000, 1'b0);
    send_point(-16'sd1, -16'sd1, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b1);
    // bit patterns across the sign boundary
    send_point(16'sh00ff, 16'shff00, 1'b0);
    send_point(16'shff00, 16'sh00ff, 1'b0);
    send_point(16'sh5555, 16'shaaaa, 1'b1);
  endtask

  // Fill the store, then drop two more points, the second one closing the set.
  task automatic test_overflow();
    send_idle_pct  = 0;
    recv_stall_pct = 20;
    for (int unsigned k = 0; k < MAX_POINTS + 2; k++)
      send_point(coord_t'($urandom), coord_t'($urandom), k == MAX_POINTS + 1);
    // drop flag must clear for the next set
    send_random_set(3);
  endtask

  task automatic test_random(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned sent;
    int unsigned size;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < ITEMS_PER_PHASE) begin
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
      send_random_set(size);
      sent += size;
    end
  endtask

  // Receiver holds off while sets keep coming, so the input side backs up.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = HOLD_CYCLES;
    for (int unsigned k = 0; k < 5; k++)
      send_random_set(4);
  endtask

  always @(posedge clk) begin : drive_ready
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    pair_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        log_mismatch("result transaction with nothing expected");
      end else begin
        want = pending_results.pop_front();
        compare_field("first_x", 64'(out_first_x), 64'(want.first_x));
        compare_field("first_y", 64'(out_first_y), 64'(want.first_y));
        compare_field("second_x", 64'(out_second_x), 64'(want.second_x));
        compare_field("second_y", 64'(out_second_y), 64'(want.second_y));
        compare_field("squared_distance", 64'(out_squared_distance),
                      64'(want.sq_dist));
        compare_field("result_valid", 64'(out_result_valid), 64'(want.pair_found));
        compare_field("overflowed", 64'(out_overflowed), 64'(want.dropped));
      end
      result_index++;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("closest_pair_of_points: mismatch");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_overflow();
    test_random(0, 0);
    test_random(63, 0);
    test_random(0, 63);
    test_random(20, 20);
    test_backpressure();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("closest_pair_of_points: match");
    end else begin
      $display("closest_pair_of_points: mismatch");
    end
    $finish;
  end

endmodule
